// ----- rtl/core/lnsc_pkg.sv -----
package lnsc_pkg;

    localparam int TimerWidth = 23;
    localparam int LfsrWidth  = 15;
    localparam int LenWidth   = 7;
    localparam int VolWidth   = 4;
    localparam int TableWidth = 64;

    localparam logic [TableWidth-1:0] DivisorTableReset = 64'h7060_5040_3020_1008;
    localparam logic [LfsrWidth-1:0]  LfsrOnes          = 15'h7FFF;
    localparam logic [LenWidth-1:0]   LengthFull        = 7'd64;
    localparam logic [3:0]            EnvDefaultPeriod  = 4'd8;
    localparam logic [VolWidth-1:0]   VolMax            = 4'd15;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_WRITE      = 2'd1,
        OP_LENGTH_CLK = 2'd2,
        OP_ENV_CLK    = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_LENGTH   = 3'd1;
    localparam logic [2:0] REG_ENVELOPE = 3'd2;
    localparam logic [2:0] REG_POLY     = 3'd3;
    localparam logic [2:0] REG_CONTROL  = 3'd4;

    typedef struct packed {
        opcode_t    opcode;
        logic [2:0] reg_index;
        logic [7:0] write_value;
    } item_t;

    typedef struct packed {
        logic [VolWidth-1:0] sample;
        logic                status_on;
    } result_t;

endpackage

// ----- rtl/core/lfsr_noise_sound_channel_core.sv -----
// Noise sound channel: 15-bit LFSR noise source with a volume envelope and a
// length counter. Each input word carries an opcode (timer tick, register
// write, length clock or envelope clock) with a register index and a byte.
// Every input word yields exactly one output word holding the current sample
// and the status bit, taken after that word has updated the channel.
// The divisor table is loaded through the cfg channel, which is always ready;
// it should only be written while no words are in flight.
// An accepted word is held in the input register, and the state update loads
// its result into the output register as soon as that register can take it.
// Throughput is one word per cycle while the receiver does not stall, set by
// the state update that sits between the input register and the output register.
// When the receiver stalls, the output register holds its word, the held
// input word waits, and in_ready drops once both are occupied.
// Reset clears both pipeline stages, sets the LFSR to all ones, loads the
// default divisor table and clears all other channel state.
module lfsr_noise_sound_channel_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          opcode,
    input  logic [2:0]                          reg_index,
    input  logic [7:0]                          write_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lnsc_pkg::VolWidth-1:0]       sample,
    output logic                                status_on,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lnsc_pkg::TableWidth-1:0]     cfg_data
);
    import lnsc_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    logic    advance;
    result_t result;
    result_t out_result;

    assign in_item.opcode      = opcode_t'(opcode);
    assign in_item.reg_index   = reg_index;
    assign in_item.write_value = write_value;

    assign advance = item_valid && can_load;

    lnsc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lnsc_channel_state u_channel_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item      (item),
        .result    (result)
    );

    lnsc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign sample    = out_result.sample;
    assign status_on = out_result.status_on;

endmodule

// ----- rtl/core/lnsc_in_stage.sv -----
module lnsc_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lnsc_pkg::item_t in_item,
    input  logic            advance,
    output logic            item_valid,
    output lnsc_pkg::item_t item
);
    import lnsc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // A word may enter when the stage is empty or the held one leaves in the same cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/core/lnsc_channel_state.sv -----
module lnsc_channel_state (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lnsc_pkg::TableWidth-1:0]     cfg_data,
    input  logic                                step,
    input  lnsc_pkg::item_t                     item,
    output lnsc_pkg::result_t                   result
);
    import lnsc_pkg::*;

    logic [TableWidth-1:0] table_reg;
    logic [LfsrWidth-1:0]  lfsr_reg,        lfsr_next;
    logic [TimerWidth-1:0] timer_reg,       timer_next;
    logic [LenWidth-1:0]   length_reg,      length_next;
    logic                  chan_on_reg,     chan_on_next;
    logic                  dac_on_reg,      dac_on_next;
    logic [VolWidth-1:0]   start_vol_reg,   start_vol_next;
    logic [VolWidth-1:0]   vol_reg,         vol_next;
    logic                  env_inc_reg,     env_inc_next;
    logic [2:0]            env_period_reg,  env_period_next;
    logic [3:0]            env_count_reg,   env_count_next;
    logic                  env_run_reg,     env_run_next;
    logic                  len_en_reg,      len_en_next;
    logic [3:0]            shift_reg,       shift_next;
    logic                  short_reg,       short_next;
    logic [2:0]            div_sel_reg,     div_sel_next;

    logic [7:0]            div_base;
    logic [TimerWidth-1:0] reload;
    logic [TimerWidth-1:0] timer_dec;
    logic                  feedback;
    logic [LfsrWidth-1:0]  lfsr_shifted;
    logic [VolWidth-1:0]   vol_stepped;
    logic [LenWidth-1:0]   length_dec;

    assign cfg_ready = 1'b1;

    assign div_base  = table_reg[{div_sel_reg, 3'b000} +: 8];
    assign reload    = TimerWidth'(div_base) << shift_reg;
    assign timer_dec = timer_reg - TimerWidth'(1);

    assign feedback  = lfsr_reg[0] ^ lfsr_reg[1];
    always_comb
    begin
        lfsr_shifted = {feedback, lfsr_reg[LfsrWidth-1:1]};
        if (short_reg)
        begin
            lfsr_shifted[6] = feedback;
        end
    end

    // Saturating envelope step; a zero period leaves the volume alone.
    always_comb
    begin
        vol_stepped = vol_reg;
        if (env_period_reg != 3'd0)
        begin
            if (env_inc_reg && vol_reg != VolMax)
            begin
                vol_stepped = vol_reg + VolWidth'(1);
            end
            else if (!env_inc_reg && vol_reg != '0)
            begin
                vol_stepped = vol_reg - VolWidth'(1);
            end
        end
    end

    assign length_dec = length_reg - LenWidth'(1);

    always_comb
    begin
        lfsr_next       = lfsr_reg;
        timer_next      = timer_reg;
        length_next     = length_reg;
        chan_on_next    = chan_on_reg;
        dac_on_next     = dac_on_reg;
        start_vol_next  = start_vol_reg;
        vol_next        = vol_reg;
        env_inc_next    = env_inc_reg;
        env_period_next = env_period_reg;
        env_count_next  = env_count_reg;
        env_run_next    = env_run_reg;
        len_en_next     = len_en_reg;
        shift_next      = shift_reg;
        short_next      = short_reg;
        div_sel_next    = div_sel_reg;

        if (step)
        begin
            unique case (item.opcode)
                OP_TICK:
                begin
                    // Reloads when the decrement hits zero; a timer at zero wraps to all ones instead.
                    if (timer_dec == '0)
                    begin
                        timer_next = reload;
                        lfsr_next  = lfsr_shifted;
                    end
                    else
                    begin
                        timer_next = timer_dec;
                    end
                end
                OP_WRITE:
                begin
                    unique case (item.reg_index)
                        REG_LENGTH:
                        begin
                            length_next = LengthFull - LenWidth'(item.write_value[5:0]);
                        end
                        REG_ENVELOPE:
                        begin
                            dac_on_next     = item.write_value[7:3] != 5'd0;
                            start_vol_next  = item.write_value[7:4];
                            vol_next        = item.write_value[7:4];
                            env_inc_next    = item.write_value[3];
                            env_period_next = item.write_value[2:0];
                            env_count_next  = {1'b0, item.write_value[2:0]};
                        end
                        REG_POLY:
                        begin
                            shift_next   = item.write_value[7:4];
                            short_next   = item.write_value[3];
                            div_sel_next = item.write_value[2:0];
                        end
                        REG_CONTROL:
                        begin
                            len_en_next = item.write_value[6];
                            if (item.write_value[7])
                            begin
                                chan_on_next = 1'b1;
                                if (length_reg == '0)
                                begin
                                    length_next = LengthFull;
                                end
                                timer_next     = reload;
                                vol_next       = start_vol_reg;
                                env_count_next = {1'b0, env_period_reg};
                                env_run_next   = 1'b1;
                                lfsr_next      = LfsrOnes;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_LENGTH_CLK:
                begin
                    if (len_en_reg && length_reg != '0)
                    begin
                        length_next = length_dec;
                        if (length_dec == '0)
                        begin
                            chan_on_next = 1'b0;
                        end
                    end
                end
                OP_ENV_CLK:
                begin
                    if (env_run_reg)
                    begin
                        if (env_count_reg <= 4'd1)
                        begin
                            env_count_next = (env_period_reg == 3'd0) ? EnvDefaultPeriod
                                                                      : {1'b0, env_period_reg};
                            vol_next = vol_stepped;
                            if (vol_stepped == '0 || vol_stepped == VolMax)
                            begin
                                env_run_next = 1'b0;
                            end
                        end
                        else
                        begin
                            env_count_next = env_count_reg - 4'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The result reflects the state left behind by this word.
    assign result.sample    = (chan_on_next && dac_on_next && !lfsr_next[0]) ? vol_next : '0;
    assign result.status_on = (length_next != '0) || !len_en_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg      <= DivisorTableReset;
            lfsr_reg       <= LfsrOnes;
            timer_reg      <= '0;
            length_reg     <= '0;
            chan_on_reg    <= 1'b0;
            dac_on_reg     <= 1'b0;
            start_vol_reg  <= '0;
            vol_reg        <= '0;
            env_inc_reg    <= 1'b0;
            env_period_reg <= '0;
            env_count_reg  <= '0;
            env_run_reg    <= 1'b0;
            len_en_reg     <= 1'b0;
            shift_reg      <= '0;
            short_reg      <= 1'b0;
            div_sel_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                table_reg <= cfg_data;
            end
            lfsr_reg       <= lfsr_next;
            timer_reg      <= timer_next;
            length_reg     <= length_next;
            chan_on_reg    <= chan_on_next;
            dac_on_reg     <= dac_on_next;
            start_vol_reg  <= start_vol_next;
            vol_reg        <= vol_next;
            env_inc_reg    <= env_inc_next;
            env_period_reg <= env_period_next;
            env_count_reg  <= env_count_next;
            env_run_reg    <= env_run_next;
            len_en_reg     <= len_en_next;
            shift_reg      <= shift_next;
            short_reg      <= short_next;
            div_sel_reg    <= div_sel_next;
        end
    end

endmodule

// ----- rtl/core/lnsc_out_stage.sv -----
module lnsc_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lnsc_pkg::result_t result,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output lnsc_pkg::result_t out_result
);
    import lnsc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
